// File: src/apd_pkg.sv
package apd_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int CHAR_W     = 8;
   localparam int FMT_W      = 2;
   localparam int TOKEN_W    = 17;
   localparam int MAXV_W     = 16;
   localparam int PIXEL_W    = 8;
   localparam int INDEX_W    = 24;
   localparam int TOTAL_W    = 25;
   localparam int DIVIDEND_W = TOKEN_W + PIXEL_W;
   localparam int STEP_W     = $clog2(PIXEL_W + 1);

   localparam logic [TOKEN_W-1:0] TOKEN_MAX  = 17'd131071;
   localparam logic [TOKEN_W-1:0] MAXV_LIMIT = 17'd65535;
   localparam logic [TOTAL_W-1:0] PIX_LIMIT  = 25'd16777216;
   localparam logic [PIXEL_W-1:0] PIXEL_FULL = 8'd255;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

   localparam logic [FMT_W-1:0] FMT_P1 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_P2 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_P3 = 2'd2;

   typedef struct packed {
      logic [CHAR_W-1:0] char_byte;
      logic              end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] blue;
      logic [INDEX_W-1:0] pixel_index;
      logic               last_pixel;
      logic               error;
   } rsp_item_type;

   typedef struct packed {
      logic               done;
      logic [PIXEL_W-1:0] quotient;
   } div_result_type;

endpackage

// File: src/apd_div_unit.sv
module apd_div_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [apd_pkg::DIVIDEND_W-1:0]       dividend,
   input  logic [apd_pkg::MAXV_W-1:0]           divisor,
   output apd_pkg::div_result_type              result
);

   localparam int ShiftW = apd_pkg::MAXV_W + apd_pkg::PIXEL_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [apd_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [apd_pkg::DIVIDEND_W-1:0]    rem_ff, rem_in;
   logic [ShiftW-1:0]                 shift_ff, shift_in;
   logic [apd_pkg::PIXEL_W:0]         quot_ff, quot_in;
   logic [apd_pkg::DIVIDEND_W-1:0]    trial;
   logic                              fits;

   // one compare-subtract per cycle, quotient bit 8 down to bit 0
   assign trial = apd_pkg::DIVIDEND_W'(shift_ff);
   assign fits  = rem_ff >= trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = apd_pkg::STEP_W'(apd_pkg::PIXEL_W);
         rem_in   = dividend;
         shift_in = {divisor, apd_pkg::PIXEL_W'(0)};
         quot_in  = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_ff - trial : rem_ff;
         quot_in  = {quot_ff[apd_pkg::PIXEL_W-1:0], fits};
         shift_in = shift_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      quot_ff  <= quot_in;
   end

   // top bit set means the true quotient is 256 or more: saturate
   assign result.done     = done_ff;
   assign result.quotient = quot_ff[apd_pkg::PIXEL_W] ? apd_pkg::PIXEL_FULL
                                                      : quot_ff[apd_pkg::PIXEL_W-1:0];

endmodule

// File: src/ascii_pnm_pixel_decoder_unit.sv
// ASCII netpbm (P1/P2/P3) pixel decoder.
// req channel: one file byte per item plus an end-of-stream flag; accepted on
//   a rising edge with req_valid high and req_stall low. The first two bytes
//   (magic) are dropped; then width, height, maxval (P2/P3) and samples.
// rsp channel: one RGB pixel with its raster index, or an error item; taken
//   on an edge with rsp_valid high and rsp_stall low.
// csr channel: writes the format (0 P1, 1 P2, 2/3 P3); csr_ready is always
//   high. Write only while the block is idle.
// Timing: items go through one at a time under a small sequencer; req_stall
//   is high from acceptance until the sequencer is back in idle.
//   Digit, magic or comment byte: ST_CHAR; blank or '#': ST_CHAR, ST_CLOSE (height
//   token adds ST_MUL for the width*height product); an error adds ST_OUT.
//   Byte that closes a P2/P3 sample: also ST_DIV, where the compare-subtract divider
//   runs 9 steps for value*255/maxval, then ST_PIX (ST_OUT per pixel); P1 skips ST_DIV.
// The finished item sits in an output register; while rsp_stall holds it,
//   the next byte is still taken, and a further result waits in the
//   sequencer until the register frees.
// Reset (synchronous): parser back to the magic bytes, format = P2, no
//   result pending. After the last pixel or an error all bytes are taken
//   and dropped until reset.
module ascii_pnm_pixel_decoder_unit #(
   parameter int MaxDim = apd_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  apd_pkg::req_item_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output apd_pkg::rsp_item_type         rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [apd_pkg::FMT_W-1:0]     csr_data
);

   localparam int DimW  = $clog2(MaxDim + 1);
   localparam int ProdW = 2 * DimW;
   localparam int CmpW  = (ProdW > apd_pkg::TOTAL_W) ? ProdW : apd_pkg::TOTAL_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHAR  = 7'b0000010,
      ST_CLOSE = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_PIX   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } seq_state_type;

   typedef enum logic [4:0] {
      PH_MAGIC  = 5'b00001,
      PH_WIDTH  = 5'b00010,
      PH_HEIGHT = 5'b00100,
      PH_MAXV   = 5'b01000,
      PH_PIX    = 5'b10000
   } parse_phase_type;

   seq_state_type                    state_ff, state_in;
   parse_phase_type                  phase_ff, phase_in;
   logic                             magic_one_ff, magic_one_in;
   logic [apd_pkg::TOKEN_W-1:0]      acc_ff, acc_in;
   logic                             in_token_ff, in_token_in;
   logic                             in_comment_ff, in_comment_in;
   logic [DimW-1:0]                  width_ff, width_in;
   logic [apd_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic [apd_pkg::MAXV_W-1:0]       maxval_ff, maxval_in;
   logic [apd_pkg::INDEX_W-1:0]      pixels_ff, pixels_in;
   logic [1:0]                       chan_ff, chan_in;
   logic [apd_pkg::PIXEL_W-1:0]      held_red_ff, held_red_in;
   logic [apd_pkg::PIXEL_W-1:0]      held_green_ff, held_green_in;
   logic                             halted_ff, halted_in;
   logic [apd_pkg::FMT_W-1:0]        format_ff, format_in;
   logic [apd_pkg::CHAR_W-1:0]       byte_ff, byte_in;
   logic                             eos_ff, eos_in;
   logic [DimW-1:0]                  value_ff, value_in;
   logic [apd_pkg::PIXEL_W-1:0]      scaled_ff, scaled_in;
   apd_pkg::rsp_item_type            pend_ff, pend_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   apd_pkg::rsp_item_type            rsp_data_ff, rsp_data_in;

   logic                             accept;
   logic                             is_digit, is_blank, is_hash;
   logic [apd_pkg::TOKEN_W+3:0]      acc_wide;
   logic [ProdW-1:0]                 prod;
   logic [CmpW-1:0]                  prod_cmp;
   logic                             is_last;
   logic [apd_pkg::INDEX_W-1:0]      pixels_next;
   logic                             div_start;
   logic [apd_pkg::DIVIDEND_W-1:0]   dividend;
   apd_pkg::div_result_type          div_result;
   apd_pkg::rsp_item_type            err_item;
   apd_pkg::rsp_item_type            err_item_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // byte classes
   assign is_digit = (byte_ff >= apd_pkg::CHAR_ZERO) && (byte_ff <= apd_pkg::CHAR_NINE);
   assign is_hash  = (byte_ff == apd_pkg::CHAR_HASH);
   assign is_blank = (byte_ff == apd_pkg::CHAR_SPACE) || (byte_ff == apd_pkg::CHAR_TAB) ||
                     (byte_ff == apd_pkg::CHAR_CR) || (byte_ff == apd_pkg::CHAR_LF);

   // acc*10 + digit, saturated later
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                     (apd_pkg::TOKEN_W + 4)'(byte_ff - apd_pkg::CHAR_ZERO);

   // width*height, register after it in the total
   assign prod     = ProdW'(width_ff) * ProdW'(value_ff);
   assign prod_cmp = CmpW'(prod);

   assign pixels_next = pixels_ff + 1'b1;
   assign is_last     = ({1'b0, pixels_ff} + 1'b1) == total_ff;

   // value*255 = (value << 8) - value
   assign dividend  = (apd_pkg::DIVIDEND_W'(acc_ff) << apd_pkg::PIXEL_W) -
                      apd_pkg::DIVIDEND_W'(acc_ff);

   always_comb begin
      err_item             = '0;
      err_item.pixel_index = pixels_ff;
      err_item.error       = 1'b1;
      err_item_next             = '0;
      err_item_next.pixel_index = pixels_next;
      err_item_next.error       = 1'b1;
   end

   apd_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (maxval_ff),
      .result   (div_result)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      magic_one_in  = magic_one_ff;
      acc_in        = acc_ff;
      in_token_in   = in_token_ff;
      in_comment_in = in_comment_ff;
      width_in      = width_ff;
      total_in      = total_ff;
      maxval_in     = maxval_ff;
      pixels_in     = pixels_ff;
      chan_in       = chan_ff;
      held_red_in   = held_red_ff;
      held_green_in = held_green_ff;
      halted_in     = halted_ff;
      format_in     = format_ff;
      byte_in       = byte_ff;
      eos_in        = eos_ff;
      value_in      = value_ff;
      scaled_in     = scaled_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;

      if (csr_valid && csr_ready) begin
         format_in = csr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in  = req_data.char_byte;
               eos_in   = req_data.end_of_stream;
               state_in = ST_CHAR;
            end
         end

         ST_CHAR: begin
            if (halted_ff) begin
               state_in = ST_IDLE;
            end else if (phase_ff == PH_MAGIC) begin
               magic_one_in = 1'b1;
               if (magic_one_ff) begin
                  phase_in = PH_WIDTH;
               end
               state_in = eos_ff ? ST_CLOSE : ST_IDLE;
            end else if (in_comment_ff) begin
               if (byte_ff == apd_pkg::CHAR_LF) begin
                  in_comment_in = 1'b0;
               end
               state_in = eos_ff ? ST_CLOSE : ST_IDLE;
            end else if (is_digit) begin
               acc_in      = (acc_wide > (apd_pkg::TOKEN_W + 4)'(apd_pkg::TOKEN_MAX))
                             ? apd_pkg::TOKEN_MAX : acc_wide[apd_pkg::TOKEN_W-1:0];
               in_token_in = 1'b1;
               state_in    = eos_ff ? ST_CLOSE : ST_IDLE;
            end else if (is_blank || is_hash) begin
               if (is_hash) begin
                  in_comment_in = 1'b1;
               end
               state_in = ST_CLOSE;
            end else begin
               pend_in   = err_item;
               halted_in = 1'b1;
               state_in  = ST_OUT;
            end
         end

         // token close; end of stream without a final pixel is an error
         ST_CLOSE: begin
            if (!in_token_ff) begin
               if (eos_ff) begin
                  pend_in   = err_item;
                  halted_in = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               acc_in      = '0;
               in_token_in = 1'b0;
               value_in    = acc_ff[DimW-1:0];
               state_in    = eos_ff ? ST_OUT : ST_IDLE;
               pend_in     = err_item;
               halted_in   = eos_ff;
               unique case (phase_ff)
                  PH_WIDTH: begin
                     if (acc_ff == '0 || acc_ff > apd_pkg::TOKEN_W'(MaxDim)) begin
                        halted_in = 1'b1;
                        state_in  = ST_OUT;
                     end else begin
                        width_in = acc_ff[DimW-1:0];
                        phase_in = PH_HEIGHT;
                     end
                  end
                  PH_HEIGHT: begin
                     if (acc_ff == '0 || acc_ff > apd_pkg::TOKEN_W'(MaxDim)) begin
                        halted_in = 1'b1;
                        state_in  = ST_OUT;
                     end else begin
                        halted_in = 1'b0;
                        state_in  = ST_MUL;
                     end
                  end
                  PH_MAXV: begin
                     if (acc_ff == '0 || acc_ff > apd_pkg::MAXV_LIMIT) begin
                        halted_in = 1'b1;
                        state_in  = ST_OUT;
                     end else begin
                        maxval_in = acc_ff[apd_pkg::MAXV_W-1:0];
                        phase_in  = PH_PIX;
                        chan_in   = 2'd0;
                     end
                  end
                  PH_PIX: begin
                     halted_in = 1'b0;
                     if (format_ff == apd_pkg::FMT_P1 || maxval_ff == '0) begin
                        scaled_in = (acc_ff != '0) ? apd_pkg::PIXEL_FULL : '0;
                        state_in  = ST_PIX;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                     halted_in = 1'b1;
                     state_in  = ST_OUT;
                  end
               endcase
            end
         end

         ST_MUL: begin
            if (prod_cmp > CmpW'(apd_pkg::PIX_LIMIT)) begin
               pend_in   = err_item;
               halted_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               total_in = prod_cmp[apd_pkg::TOTAL_W-1:0];
               phase_in = (format_ff == apd_pkg::FMT_P1) ? PH_PIX : PH_MAXV;
               chan_in  = 2'd0;
               if (eos_ff) begin
                  pend_in   = err_item;
                  halted_in = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_DIV: begin
            if (div_result.done) begin
               scaled_in = div_result.quotient;
               state_in  = ST_PIX;
            end
         end

         // place the sample: hold red and green for P3, emit on the last
         ST_PIX: begin
            if (format_ff >= apd_pkg::FMT_P3 && chan_ff == 2'd0) begin
               held_red_in = scaled_ff;
               chan_in     = 2'd1;
            end else if (format_ff >= apd_pkg::FMT_P3 && chan_ff == 2'd1) begin
               held_green_in = scaled_ff;
               chan_in       = 2'd2;
            end else begin
               chan_in   = 2'd0;
               pixels_in = pixels_next;
            end

            if (format_ff >= apd_pkg::FMT_P3 && (chan_ff == 2'd0 || chan_ff == 2'd1)) begin
               if (eos_ff) begin
                  pend_in   = err_item;
                  halted_in = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (eos_ff && !is_last) begin
               pend_in   = err_item_next;
               halted_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               pend_in.red         = (format_ff >= apd_pkg::FMT_P3) ? held_red_ff : scaled_ff;
               pend_in.green       = (format_ff >= apd_pkg::FMT_P3) ? held_green_ff : scaled_ff;
               pend_in.blue        = scaled_ff;
               pend_in.pixel_index = pixels_ff;
               pend_in.last_pixel  = is_last;
               pend_in.error       = 1'b0;
               halted_in           = is_last;
               state_in            = ST_OUT;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_MAGIC;
         magic_one_ff  <= 1'b0;
         acc_ff        <= '0;
         in_token_ff   <= 1'b0;
         in_comment_ff <= 1'b0;
         width_ff      <= '0;
         total_ff      <= '0;
         maxval_ff     <= '0;
         pixels_ff     <= '0;
         chan_ff       <= 2'd0;
         held_red_ff   <= '0;
         held_green_ff <= '0;
         halted_ff     <= 1'b0;
         format_ff     <= apd_pkg::FMT_P2;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         magic_one_ff  <= magic_one_in;
         acc_ff        <= acc_in;
         in_token_ff   <= in_token_in;
         in_comment_ff <= in_comment_in;
         width_ff      <= width_in;
         total_ff      <= total_in;
         maxval_ff     <= maxval_in;
         pixels_ff     <= pixels_in;
         chan_ff       <= chan_in;
         held_red_ff   <= held_red_in;
         held_green_ff <= held_green_in;
         halted_ff     <= halted_in;
         format_ff     <= format_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      eos_ff      <= eos_in;
      value_ff    <= value_in;
      scaled_ff   <= scaled_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
